>>> rtl/core/hbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_pkg
// Shared types and constants for the hash bucket map engine.
// ----------------------------------------------------------------------------
package hbm_pkg;

  localparam int DEF_NUM_BUCKETS  = 16;
  localparam int DEF_BUCKET_DEPTH = 8;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int ORD_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  // bucket hash rotates the key right by this many bits
  localparam int ROT_AMT  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_SET       = 3'd0,
    OP_GET       = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_KEY_OF    = 3'd3,
    OP_ORDINAL   = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_GET_MAKE  = 3'd6,
    OP_REMOVE_VAL = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_APPEND,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WALK_RD,
    S_WALK_CMP,
    S_ORD_STEP,
    S_ORD_CMP,
    S_FINISH
  } state_e;

endpackage
`default_nettype wire

>>> rtl/core/hbm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_in_if / hbm_out_if
// Valid/ready channels carrying operation requests and results.
// ----------------------------------------------------------------------------
interface hbm_in_if;
  logic                      valid;
  logic                      ready;
  logic [hbm_pkg::OP_W-1:0]  op;
  logic [hbm_pkg::KEY_W-1:0] key;
  logic [hbm_pkg::VAL_W-1:0] value;
  logic [hbm_pkg::ORD_W-1:0] ordinal;

  modport source (output valid, op, key, value, ordinal, input ready);
  modport sink   (input valid, op, key, value, ordinal, output ready);
endinterface

interface hbm_out_if;
  logic                         valid;
  logic                         ready;
  logic [hbm_pkg::STATUS_W-1:0] status;
  logic [hbm_pkg::KEY_W-1:0]    out_key;
  logic [hbm_pkg::VAL_W-1:0]    out_value;
  logic [hbm_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, status, out_key, out_value, entry_count, input ready);
  modport sink   (input valid, status, out_key, out_value, entry_count, output ready);
endinterface
`default_nettype wire

>>> rtl/core/hbm_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_hash
// Bucket index: key rotated right, reduced modulo the bucket count one byte
// per cycle through two small constant residue tables.
// ----------------------------------------------------------------------------
module hbm_hash #(
  parameter int NUM_BUCKETS = hbm_pkg::DEF_NUM_BUCKETS
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic [hbm_pkg::KEY_W-1:0]             key_i,
  output logic                                       done_o,
  output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket_o
);
  import hbm_pkg::*;

  localparam int BW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SW      = BW + 1;
  localparam int DIGIT_W = 8;
  localparam int DIGITS  = KEY_W / DIGIT_W;
  localparam int CW      = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // (r * 256) mod N for every residue r
  function automatic logic [BW-1:0] shift_mod(input logic [BW-1:0] r);
    logic [BW-1:0] res;
    res = '0;
    for (int n = 0; n < NUM_BUCKETS; n++) begin
      if (r == BW'(n)) res = BW'((n * 256) % NUM_BUCKETS);
    end
    return res;
  endfunction

  // d mod N for every byte value d
  function automatic logic [BW-1:0] byte_mod(input logic [DIGIT_W-1:0] d);
    logic [BW-1:0] res;
    res = '0;
    for (int n = 0; n < 256; n++) begin
      if (d == DIGIT_W'(n)) res = BW'(n % NUM_BUCKETS);
    end
    return res;
  endfunction

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [KEY_W-1:0]  sh_q;
  logic [BW-1:0]     rem_q, rem_d;
  logic [SW-1:0]     sum;

  // Horner step on the top byte: rem = (rem * 256 + byte) mod N
  always_comb begin
    sum = SW'(shift_mod(rem_q)) + SW'(byte_mod(sh_q[KEY_W-1 -: DIGIT_W]));
    if (sum >= SW'(NUM_BUCKETS)) begin
      rem_d = BW'(sum - SW'(NUM_BUCKETS));
    end else begin
      rem_d = BW'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= {key_i[ROT_AMT-1:0], key_i[KEY_W-1:ROT_AMT]};
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[KEY_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      rem_q <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule
`default_nettype wire

>>> rtl/core/hash_bucket_map_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hash_bucket_map_engine
// Key/value map in fixed buckets, run by a sequencer over one slot memory.
// ----------------------------------------------------------------------------
// Steps, input transfer to result valid: set/get/remove/get-or-create hash
//   the key, read and compare each slot of its bucket, on a miss append (if
//   room) for set/get-or-create, shift later entries down on a removal, and
//   finish. Key-of-value and remove-value walk the buckets comparing values,
//   removal shifting as above. Ordinal steps bucket by bucket, reading the
//   entry on a hit. Clear goes straight to finish.
// Throughput: one item at a time; the next transfer is taken the cycle after
//   the result registers, and an untaken result holds the finish step.
// Reset empties every bucket; slot contents are not cleared.
// ----------------------------------------------------------------------------
module hash_bucket_map_engine #(
  parameter int NUM_BUCKETS  = hbm_pkg::DEF_NUM_BUCKETS,
  parameter int BUCKET_DEPTH = hbm_pkg::DEF_BUCKET_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hbm_in_if.sink    in_i,
  hbm_out_if.source out_o
);
  import hbm_pkg::*;

  localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW    = $clog2(BUCKET_DEPTH + 1);
  localparam int TW    = $clog2(SLOTS + 1);

  function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
                                               input logic [FW-1:0] i);
    return AW'(AW'(b) * AW'(BUCKET_DEPTH)) + AW'(i);
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [ORD_W-1:0]  rem_q, rem_d;     // ordinal remainder
  logic [BW-1:0]     b_q, b_d;         // current bucket
  logic [FW-1:0]     i_q, i_d;         // scan slot
  logic [FW-1:0]     j_q, j_d;         // shift slot
  status_e           status_q, status_d;
  logic [KEY_W-1:0]  okey_q, okey_d;
  logic [VAL_W-1:0]  oval_q, oval_d;
  logic [FW-1:0]     fill_q [NUM_BUCKETS];
  logic [TW-1:0]     total_q, total_d;

  // result register
  logic               ovld_q;
  status_e            ostat_q;
  logic [KEY_W-1:0]   okey_out_q;
  logic [VAL_W-1:0]   oval_out_q;
  logic [COUNT_W-1:0] ocnt_q;

  // fill updates
  logic fill_inc, fill_dec, fill_clr;

  // slot memory
  logic [KEY_W-1:0] mem_k [SLOTS];
  logic [VAL_W-1:0] mem_v [SLOTS];
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             we_k, we_v;
  logic [KEY_W-1:0] wr_k, rd_k_q;
  logic [VAL_W-1:0] wr_v, rd_v_q;

  // hash unit
  logic          hash_start, hash_done;
  logic [BW-1:0] hash_bucket;

  logic          in_xfer, out_free, last_bucket, key_op;
  logic [FW-1:0] fill_cur, j_next;

  assign in_xfer     = in_i.valid & in_i.ready;
  assign out_free    = !ovld_q || out_o.ready;
  assign fill_cur    = fill_q[b_q];
  assign last_bucket = (b_q == BW'(NUM_BUCKETS - 1));
  assign j_next      = j_q + 1'b1;
  assign key_op      = (op_e'(in_i.op) == OP_SET) || (op_e'(in_i.op) == OP_GET) ||
                       (op_e'(in_i.op) == OP_REMOVE) || (op_e'(in_i.op) == OP_GET_MAKE);
  assign hash_start  = in_xfer && key_op;
  assign in_i.ready  = (state_q == S_IDLE);

  hbm_hash #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .key_i    (in_i.key),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (op_e'(in_i.op))
            OP_KEY_OF, OP_REMOVE_VAL: state_d = S_WALK_RD;
            OP_ORDINAL:               state_d = S_ORD_STEP;
            OP_CLEAR:                 state_d = S_FINISH;
            default:                  state_d = S_HASH;
          endcase
        end
      end
      S_HASH:     if (hash_done) state_d = S_SCAN_RD;
      S_SCAN_RD: begin
        if (i_q < fill_cur) begin
          state_d = S_SCAN_CMP;
        end else if ((op_q == OP_SET || op_q == OP_GET_MAKE) &&
                     (fill_cur < FW'(BUCKET_DEPTH))) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN_CMP: begin
        if (rd_k_q == key_q) begin
          state_d = (op_q == OP_REMOVE) ? S_SHIFT_RD : S_FINISH;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_APPEND:   state_d = S_FINISH;
      S_SHIFT_RD: begin
        if (j_next < fill_cur) begin
          state_d = S_SHIFT_WR;
        end else begin
          state_d = (op_q == OP_REMOVE_VAL) ? S_WALK_RD : S_FINISH;
        end
      end
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      S_WALK_RD: begin
        if (i_q < fill_cur)  state_d = S_WALK_CMP;
        else if (last_bucket) state_d = S_FINISH;
      end
      S_WALK_CMP: begin
        if (rd_v_q == val_q) begin
          state_d = (op_q == OP_KEY_OF) ? S_FINISH : S_SHIFT_RD;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_ORD_STEP: begin
        if (rem_q < ORD_W'(fill_cur)) state_d = S_ORD_CMP;
        else if (last_bucket)         state_d = S_FINISH;
      end
      S_ORD_CMP:  state_d = S_FINISH;
      S_FINISH:   if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    op_d     = op_q;
    key_d    = key_q;
    val_d    = val_q;
    rem_d    = rem_q;
    b_d      = b_q;
    i_d      = i_q;
    j_d      = j_q;
    status_d = status_q;
    okey_d   = okey_q;
    oval_d   = oval_q;
    total_d  = total_q;
    fill_inc = 1'b0;
    fill_dec = 1'b0;
    fill_clr = 1'b0;
    rd_addr  = slot_addr(b_q, i_q);
    wr_addr  = slot_addr(b_q, i_q);
    we_k     = 1'b0;
    we_v     = 1'b0;
    wr_k     = key_q;
    wr_v     = val_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d     = op_e'(in_i.op);
          key_d    = in_i.key;
          val_d    = in_i.value;
          rem_d    = in_i.ordinal;
          b_d      = '0;
          i_d      = '0;
          status_d = ST_MISS;
          okey_d   = '0;
          oval_d   = '0;
          if (op_e'(in_i.op) == OP_CLEAR) begin
            fill_clr = 1'b1;
            total_d  = '0;
            status_d = ST_OK;
          end
        end
      end
      S_HASH: begin
        b_d = hash_bucket;
        i_d = '0;
      end
      S_SCAN_RD: begin
        if (!(i_q < fill_cur) && (op_q == OP_SET || op_q == OP_GET_MAKE) &&
            !(fill_cur < FW'(BUCKET_DEPTH))) begin
          status_d = ST_FULL;
        end
      end
      S_SCAN_CMP: begin
        if (rd_k_q == key_q) begin
          status_d = ST_OK;
          j_d      = i_q;
          if (op_q == OP_SET) begin
            we_v = 1'b1;
          end else if (op_q == OP_GET || op_q == OP_GET_MAKE) begin
            oval_d = rd_v_q;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_APPEND: begin
        wr_addr  = slot_addr(b_q, fill_cur);
        we_k     = 1'b1;
        we_v     = 1'b1;
        wr_v     = (op_q == OP_SET) ? val_q : '0;
        fill_inc = 1'b1;
        total_d  = total_q + 1'b1;
        status_d = ST_OK;
      end
      S_SHIFT_RD: begin
        rd_addr = slot_addr(b_q, j_next);
        if (!(j_next < fill_cur)) begin
          fill_dec = 1'b1;
          total_d  = total_q - 1'b1;
        end
      end
      S_SHIFT_WR: begin
        wr_addr = slot_addr(b_q, j_q);
        we_k    = 1'b1;
        we_v    = 1'b1;
        wr_k    = rd_k_q;
        wr_v    = rd_v_q;
        j_d     = j_next;
      end
      S_WALK_RD: begin
        if (!(i_q < fill_cur) && !last_bucket) begin
          b_d = b_q + 1'b1;
          i_d = '0;
        end
      end
      S_WALK_CMP: begin
        if (rd_v_q == val_q) begin
          status_d = ST_OK;
          okey_d   = (op_q == OP_KEY_OF) ? rd_k_q : '0;
          j_d      = i_q;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_ORD_STEP: begin
        rd_addr = slot_addr(b_q, FW'(rem_q));
        if (!(rem_q < ORD_W'(fill_cur))) begin
          rem_d = rem_q - ORD_W'(fill_cur);
          if (!last_bucket) b_d = b_q + 1'b1;
        end
      end
      S_ORD_CMP: begin
        status_d = ST_OK;
        okey_d   = rd_k_q;
        oval_d   = rd_v_q;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      ovld_q  <= 1'b0;
      for (int n = 0; n < NUM_BUCKETS; n++) begin
        fill_q[n] <= '0;
      end
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (fill_clr) begin
        for (int n = 0; n < NUM_BUCKETS; n++) begin
          fill_q[n] <= '0;
        end
      end else if (fill_inc) begin
        fill_q[b_q] <= fill_cur + 1'b1;
      end else if (fill_dec) begin
        fill_q[b_q] <= fill_cur - 1'b1;
      end
      if (state_q == S_FINISH && out_free) begin
        ovld_q <= 1'b1;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    rem_q    <= rem_d;
    b_q      <= b_d;
    i_q      <= i_d;
    j_q      <= j_d;
    status_q <= status_d;
    okey_q   <= okey_d;
    oval_q   <= oval_d;
    if (state_q == S_FINISH && out_free) begin
      ostat_q    <= status_q;
      okey_out_q <= okey_q;
      oval_out_q <= oval_q;
      ocnt_q     <= COUNT_W'(total_q);
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (we_k) mem_k[wr_addr] <= wr_k;
    if (we_v) mem_v[wr_addr] <= wr_v;
    rd_k_q <= mem_k[rd_addr];
    rd_v_q <= mem_v[rd_addr];
  end

  assign out_o.valid       = ovld_q;
  assign out_o.status      = ostat_q;
  assign out_o.out_key     = okey_out_q;
  assign out_o.out_value   = oval_out_q;
  assign out_o.entry_count = ocnt_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(SLOTS))
    else $error("entry total above capacity");

  // bucket pointer is only meaningful once an operation is running
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (fill_cur <= FW'(BUCKET_DEPTH)))
    else $error("bucket fill above depth");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != S_IDLE))
    else $error("sequencer idle right after input transfer");

  a_full_only_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && status_q == ST_FULL) |->
      (op_q == OP_SET || op_q == OP_GET_MAKE))
    else $error("bucket full reported for non-inserting op");

endmodule
`default_nettype wire

>>> sim/hash_bucket_map_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_bucket_map_engine_test
// Drives map operations through the request channel, predicts every result
// with a local bucket map and compares each response field by field.
// ----------------------------------------------------------------------------
module hash_bucket_map_engine_test;
  import hbm_pkg::*;

  localparam int NB    = DEF_NUM_BUCKETS;
  localparam int DEPTH = DEF_BUCKET_DEPTH;

  typedef struct packed {
    status_e                status;
    logic [KEY_W-1:0]       out_key;
    logic [VAL_W-1:0]       out_value;
    logic [COUNT_W-1:0]     entry_count;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hbm_in_if  req_if ();
  hbm_out_if rsp_if ();

  hash_bucket_map_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (rsp_if.source)
  );

  // model of the map contents
  logic [KEY_W-1:0] map_keys [NB][DEPTH];
  logic [VAL_W-1:0] map_vals [NB][DEPTH];
  int               map_fill [NB];
  int               map_total;

  reply_t expected_replies[$];
  int     error_count;
  int     reply_count;
  int     send_idle_pct;   // sender idle chance, percent
  int     recv_stall_pct;  // receiver stall chance, percent

  // small pool of keys and values so hits, full buckets and repeats occur
  logic [KEY_W-1:0] key_pool [32];
  logic [VAL_W-1:0] val_pool [8];

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("Timeout after %0d replies", reply_count);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int bucket_of(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    r = {k[ROT_AMT-1:0], k[KEY_W-1:ROT_AMT]};
    return int'(r % NB);
  endfunction

  function automatic int slot_of(int b, logic [KEY_W-1:0] k);
    for (int i = 0; i < map_fill[b]; i++)
      if (map_keys[b][i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int b, int i);
    for (int j = i; j + 1 < map_fill[b]; j++) begin
      map_keys[b][j] = map_keys[b][j+1];
      map_vals[b][j] = map_vals[b][j+1];
    end
    map_fill[b]--;
    map_total--;
  endfunction

  function automatic status_e store(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int b;
    int i;
    b = bucket_of(k);
    i = slot_of(b, k);
    if (i >= 0) begin
      map_vals[b][i] = v;
      return ST_OK;
    end
    if (map_fill[b] >= DEPTH) return ST_FULL;
    map_keys[b][map_fill[b]] = k;
    map_vals[b][map_fill[b]] = v;
    map_fill[b]++;
    map_total++;
    return ST_OK;
  endfunction

  function automatic reply_t map_apply(op_e op, logic [KEY_W-1:0] k,
                                       logic [VAL_W-1:0] v, logic [ORD_W-1:0] ord);
    reply_t r;
    int b;
    int i;
    int rem;
    bit hit;
    r = '{status: ST_MISS, out_key: '0, out_value: '0, entry_count: '0};
    case (op)
      OP_SET: r.status = store(k, v);
      OP_GET, OP_GET_MAKE: begin
        b = bucket_of(k);
        i = slot_of(b, k);
        if (i >= 0) begin
          r.status = ST_OK;
          r.out_value = map_vals[b][i];
        end else if (op == OP_GET_MAKE) begin
          r.status = store(k, '0);
        end
      end
      OP_REMOVE: begin
        b = bucket_of(k);
        i = slot_of(b, k);
        if (i >= 0) begin
          drop_slot(b, i);
          r.status = ST_OK;
        end
      end
      OP_KEY_OF: begin
        hit = 1'b0;
        for (b = 0; b < NB && !hit; b++)
          for (i = 0; i < map_fill[b] && !hit; i++)
            if (map_vals[b][i] == v) begin
              hit = 1'b1;
              r.status = ST_OK;
              r.out_key = map_keys[b][i];
            end
      end
      OP_ORDINAL: begin
        rem = int'(ord);
        hit = 1'b0;
        for (b = 0; b < NB && !hit; b++) begin
          if (rem < map_fill[b]) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.out_key = map_keys[b][rem];
            r.out_value = map_vals[b][rem];
          end else begin
            rem -= map_fill[b];
          end
        end
      end
      OP_CLEAR: begin
        foreach (map_fill[j]) map_fill[j] = 0;
        map_total = 0;
        r.status = ST_OK;
      end
      default: begin
        // remove every entry holding v; count drops too
        for (b = 0; b < NB; b++) begin
          i = 0;
          while (i < map_fill[b]) begin
            if (map_vals[b][i] == v) begin
              drop_slot(b, i);
              r.status = ST_OK;
            end else begin
              i++;
            end
          end
        end
      end
    endcase
    r.entry_count = map_total[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    error_count++;
    $display("ERROR reply %0d: %s got 0x%08h want 0x%08h", reply_count, what, got, want);
  endtask

  // one request transfer; prediction is made at acceptance
  task automatic send_op(op_e op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                         logic [ORD_W-1:0] ord);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.key     <= k;
    req_if.value   <= v;
    req_if.ordinal <= ord;
    do @(posedge clk_i); while (!req_if.ready);
    expected_replies.push_back(map_apply(op, k, v, ord));
    @(negedge clk_i);
  endtask

  // receiver: random stalls, checks at the rising edge
  always @(negedge clk_i) begin
    if (rst_ni) rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected reply", '0, '0);
      end else begin
        want = expected_replies.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", KEY_W'(rsp_if.status), KEY_W'(want.status));
        if (rsp_if.out_key !== want.out_key)
          report_mismatch("out_key", rsp_if.out_key, want.out_key);
        if (rsp_if.out_value !== want.out_value)
          report_mismatch("out_value", rsp_if.out_value, want.out_value);
        if (rsp_if.entry_count !== want.entry_count)
          report_mismatch("entry_count", KEY_W'(rsp_if.entry_count),
                          KEY_W'(want.entry_count));
      end
      reply_count++;
    end
  end

  // keys that land in a given bucket: bucket comes from key bits [7:4]
  function automatic logic [KEY_W-1:0] key_in_bucket(int b, logic [KEY_W-1:0] seed);
    return {seed[KEY_W-1:8], 4'(b), seed[3:0]};
  endfunction

  task automatic test_directed();
    // extremes of key and value
    send_op(OP_GET, 32'h0, 32'h0, '0);
    send_op(OP_SET, 32'h0, 32'hFFFF_FFFF, '0);
    send_op(OP_SET, 32'hFFFF_FFFF, 32'h0, '0);
    send_op(OP_GET, 32'hFFFF_FFFF, 32'h0, '0);
    send_op(OP_SET, 32'h0, 32'h1234_5678, '0);   // overwrite existing key
    send_op(OP_GET, 32'h0, 32'h0, '0);
    // fill one bucket past its depth
    for (int i = 0; i < DEPTH + 1; i++)
      send_op(OP_SET, key_in_bucket(5, 32'hA5A5_0000 + (i << 8)), 32'hC0DE, '0);
    send_op(OP_GET_MAKE, key_in_bucket(5, 32'h7700_0001), 32'h0, '0); // full
    send_op(OP_GET_MAKE, 32'h0000_0AB0, 32'h0, '0);
    send_op(OP_KEY_OF, 32'h0, 32'hC0DE, '0);
    send_op(OP_KEY_OF, 32'h0, 32'hDEAD_BEEF, '0);
    send_op(OP_ORDINAL, 32'h0, 32'h0, 7'd3);
    send_op(OP_ORDINAL, 32'h0, 32'h0, 7'd127);
    send_op(OP_REMOVE, key_in_bucket(5, 32'hA5A5_0100), 32'h0, '0);
    send_op(OP_REMOVE, 32'h5555_5555, 32'h0, '0);
    send_op(OP_REMOVE_VAL, 32'h0, 32'hC0DE, '0);
    send_op(OP_REMOVE_VAL, 32'h0, 32'hC0DE, '0);
    send_op(OP_CLEAR, 32'h0, 32'h0, '0);
    send_op(OP_ORDINAL, 32'h0, 32'h0, 7'd0);
  endtask

  task automatic random_item();
    op_e op;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35)      op = OP_SET;
    else if (pick < 50) op = OP_GET;
    else if (pick < 62) op = OP_REMOVE;
    else if (pick < 70) op = OP_KEY_OF;
    else if (pick < 80) op = OP_ORDINAL;
    else if (pick < 81) op = OP_CLEAR;
    else if (pick < 92) op = OP_GET_MAKE;
    else                op = OP_REMOVE_VAL;
    k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(31)];
    v = ($urandom_range(4) == 0) ? $urandom() : val_pool[$urandom_range(7)];
    send_op(op, k, v, 7'($urandom_range(127)));
  endtask

  task automatic test_random(int items, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) random_item();
  endtask

  initial begin
    error_count = 0;
    reply_count = 0;
    map_total = 0;
    foreach (map_fill[j]) map_fill[j] = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    req_if.valid = 1'b0;
    req_if.op = OP_SET;
    req_if.key = '0;
    req_if.value = '0;
    req_if.ordinal = '0;
    rsp_if.ready = 1'b0;
    // most pool keys crowd three buckets so fills and overflow happen
    foreach (key_pool[j])
      key_pool[j] = (j < 24) ? key_in_bucket(j % 3, $urandom()) : $urandom();
    foreach (val_pool[j]) val_pool[j] = $urandom();
    val_pool[0] = '0;
    val_pool[1] = '1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(250, 0, 0);
    test_random(200, 80, 0);
    test_random(200, 0, 80);
    test_random(200, 37, 37);
    req_if.valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered all eight operations, overflow, misses and idle/stall phases;");
    $display("%0d replies checked", reply_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/hbm_pkg.sv
rtl/core/hbm_if.sv
rtl/core/hbm_hash.sv
rtl/core/hash_bucket_map_engine.sv
sim/hash_bucket_map_engine_test.sv
